FILE: rtl/mm3_pkg.sv
// Shared types and constants for the 3xN by Nx3 multiply-accumulate block.
package mm3_pkg;

  localparam int unsigned OpW      = 32;
  localparam int unsigned AccW     = 64;
  localparam int unsigned NumRows  = 3;
  localparam int unsigned NumLanes = NumRows * NumRows;

  localparam int unsigned InDepthDef  = 2;
  localparam int unsigned OutDepthDef = 2;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // One reduction step: column k of A and row k of B
  typedef struct packed {
    logic signed [OpW-1:0] a_row0;
    logic signed [OpW-1:0] a_row1;
    logic signed [OpW-1:0] a_row2;
    logic signed [OpW-1:0] b_col0;
    logic signed [OpW-1:0] b_col1;
    logic signed [OpW-1:0] b_col2;
    logic                  last;
  } in_item_t;

  // Full 3x3 result, Q32.32 saturated
  typedef struct packed {
    logic signed [AccW-1:0] c00;
    logic signed [AccW-1:0] c01;
    logic signed [AccW-1:0] c02;
    logic signed [AccW-1:0] c10;
    logic signed [AccW-1:0] c11;
    logic signed [AccW-1:0] c12;
    logic signed [AccW-1:0] c20;
    logic signed [AccW-1:0] c21;
    logic signed [AccW-1:0] c22;
  } out_item_t;

endpackage

FILE: rtl/mm3_fifo.sv
// Small register-based queue used between the front, the back and the result port.
module mm3_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the item on push
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/mm3_back.sv
// Back end: nine multiply lanes, then nine saturating accumulators.
module mm3_back
  import mm3_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  input  in_item_t  op_i,
  output logic      op_ready_o,
  output logic      res_push_o,
  output out_item_t res_o,
  input  logic      res_full_i
);

  logic signed [OpW-1:0]  a_vals [NumRows];
  logic signed [OpW-1:0]  b_vals [NumRows];
  logic signed [AccW-1:0] prod_d [NumLanes];
  logic signed [AccW-1:0] prod_q [NumLanes];
  logic                   prod_valid_q, prod_valid_d;
  logic                   prod_last_q;
  logic signed [AccW-1:0] acc_q  [NumLanes];
  logic signed [AccW-1:0] acc_d  [NumLanes];
  logic signed [AccW-1:0] sat_sum [NumLanes];
  logic signed [AccW:0]   wide_sum [NumLanes];
  logic                   stall;
  logic                   acc_en;

  assign a_vals[0] = op_i.a_row0;
  assign a_vals[1] = op_i.a_row1;
  assign a_vals[2] = op_i.a_row2;
  assign b_vals[0] = op_i.b_col0;
  assign b_vals[1] = op_i.b_col1;
  assign b_vals[2] = op_i.b_col2;

  // Hold the product stage while a finished result has nowhere to go
  assign stall        = prod_valid_q && prod_last_q && res_full_i;
  assign op_ready_o   = !stall;
  assign acc_en       = prod_valid_q && !stall;
  assign prod_valid_d = stall ? prod_valid_q : op_valid_i;

  // Form the nine outer products; each fits exactly in 64 bits
  always_comb begin
    for (int i = 0; i < NumRows; i++) begin
      for (int j = 0; j < NumRows; j++) begin
        prod_d[i*NumRows + j] = a_vals[i] * b_vals[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= prod_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_ready_o && op_valid_i) begin
      prod_q      <= prod_d;
      prod_last_q <= op_i.last;
    end
  end

  // Add each product into its accumulator, clamping at the 64-bit limits
  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      wide_sum[k] = {acc_q[k][AccW-1], acc_q[k]} + {prod_q[k][AccW-1], prod_q[k]};
      if (wide_sum[k][AccW] != wide_sum[k][AccW-1]) begin
        sat_sum[k] = wide_sum[k][AccW] ? AccMin : AccMax;
      end else begin
        sat_sum[k] = wide_sum[k][AccW-1:0];
      end
      acc_d[k] = prod_last_q ? '0 : sat_sum[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumLanes; k++) begin
        acc_q[k] <= '0;
      end
    end else if (acc_en) begin
      acc_q <= acc_d;
    end
  end

  // Emit the sums on the last step of a reduction
  assign res_push_o = acc_en && prod_last_q;
  assign res_o.c00  = sat_sum[0];
  assign res_o.c01  = sat_sum[1];
  assign res_o.c02  = sat_sum[2];
  assign res_o.c10  = sat_sum[3];
  assign res_o.c11  = sat_sum[4];
  assign res_o.c12  = sat_sum[5];
  assign res_o.c20  = sat_sum[6];
  assign res_o.c21  = sat_sum[7];
  assign res_o.c22  = sat_sum[8];

endmodule

FILE: rtl/matmul_3xn_by_nx3_accumulate.sv
// Top level: 3xN by Nx3 matrix multiply with saturating Q32.32 accumulation.
// Throughput: one item per cycle, sustained, with results popped as they appear.
// Path: an accepted item waits in the input queue, then in the multiply register, then the
// accumulate stage writes the finished result into the result queue.
// Reset (rst_ni low, asynchronous) empties both queues and clears all accumulators.
module matmul_3xn_by_nx3_accumulate
  import mm3_pkg::*;
#(
  parameter int unsigned IN_DEPTH  = InDepthDef,
  parameter int unsigned OUT_DEPTH = OutDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_item_i,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  in_item_t  op;
  logic      op_empty;
  logic      op_valid;
  logic      op_ready;
  out_item_t res;
  logic      res_push;
  logic      res_full;

  // Front: accept and queue incoming items
  mm3_fifo #(
    .WIDTH ($bits(in_item_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_item_i),
    .full_o  (full),
    .pop_i   (op_ready),
    .rdata_o (op),
    .empty_o (op_empty)
  );

  assign op_valid = !op_empty;

  // Back: multiply and accumulate
  mm3_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_ready_o (op_ready),
    .res_push_o (res_push),
    .res_o      (res),
    .res_full_i (res_full)
  );

  // Hold finished results until popped
  mm3_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

  // A pushed result must show on the output the next cycle
  a_push_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> !empty)
    else $error("result pushed but output queue empty");

  // The back only stalls when the result queue is full
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !op_ready |-> res_full)
    else $error("back stalled without a full result queue");

  // A stalled operand stays queued unchanged
  a_op_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid && !op_ready) |=> (op_valid && $stable(op)))
    else $error("stalled operand lost or changed");

endmodule

FILE: dv/mm3_result_checker.sv
// Checker for the 3xN by Nx3 multiply-accumulate block: predicts each result and compares it.
module mm3_result_checker
  import mm3_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  logic      full_i,
  input  in_item_t  in_item_i,
  input  logic      empty_i,
  input  logic      pop_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  // Running Q32.32 sums, one per entry of the 3x3 product
  logic signed [AccW-1:0] run_sum [NumLanes];
  // Finished 3x3 products waiting for the block to deliver them
  out_item_t              expected_mats [$];
  int                     mismatches;

  string lane_name [NumLanes] = '{"c00", "c01", "c02", "c10", "c11", "c12",
                                  "c20", "c21", "c22"};

  initial begin
    mismatches   = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Print one line per mismatch and count it
  task automatic note_mismatch(input string what, input logic [AccW-1:0] got,
                               input logic [AccW-1:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Add the nine products of one item into the running sums, saturating per add
  task automatic fold_step(input in_item_t it);
    logic signed [OpW-1:0]  a_op [NumRows];
    logic signed [OpW-1:0]  b_op [NumRows];
    logic signed [AccW-1:0] wide_a;
    logic signed [AccW-1:0] wide_b;
    logic signed [AccW-1:0] prod;
    logic [AccW:0]          total;
    logic [NumLanes*AccW-1:0] packed_res;
    int                     lane;
    a_op[0] = it.a_row0;
    a_op[1] = it.a_row1;
    a_op[2] = it.a_row2;
    b_op[0] = it.b_col0;
    b_op[1] = it.b_col1;
    b_op[2] = it.b_col2;
    for (int r = 0; r < NumRows; r++) begin
      for (int c = 0; c < NumRows; c++) begin
        lane   = r * NumRows + c;
        wide_a = a_op[r];
        wide_b = b_op[c];
        prod   = wide_a * wide_b;
        total  = {run_sum[lane][AccW-1], run_sum[lane]} + {prod[AccW-1], prod};
        if (total[AccW] != total[AccW-1]) begin
          run_sum[lane] = total[AccW] ? AccMin : AccMax;
        end else begin
          run_sum[lane] = total[AccW-1:0];
        end
      end
    end
    // Emit on the closing item, then clear for the next reduction
    if (it.last) begin
      for (int l = 0; l < NumLanes; l++) begin
        packed_res[(NumLanes-1-l)*AccW +: AccW] = run_sum[l];
        run_sum[l] = '0;
      end
      expected_mats.push_back(out_item_t'(packed_res));
    end
  endtask

  // Watch both channels: check the delivered result, then fold the accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    logic [NumLanes*AccW-1:0] got_v;
    logic [NumLanes*AccW-1:0] want_v;
    if (!rst_ni) begin
      for (int l = 0; l < NumLanes; l++) begin
        run_sum[l] = '0;
      end
      expected_mats.delete();
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        got_v = out_item_i;
        if (expected_mats.size() == 0) begin
          note_mismatch("result with nothing pending", got_v[NumLanes*AccW-1 -: AccW], '0);
        end else begin
          want_v = expected_mats.pop_front();
          for (int l = 0; l < NumLanes; l++) begin
            if (got_v[(NumLanes-1-l)*AccW +: AccW] !== want_v[(NumLanes-1-l)*AccW +: AccW]) begin
              note_mismatch(lane_name[l], got_v[(NumLanes-1-l)*AccW +: AccW],
                            want_v[(NumLanes-1-l)*AccW +: AccW]);
            end
          end
        end
      end
      if (push_i && !full_i) begin
        fold_step(in_item_i);
      end
      pending_o <= expected_mats.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

FILE: dv/testbench.sv
// Top of the testbench: clock, reset, item stimulus, result draining and the verdict.
module testbench;
  import mm3_pkg::*;

  localparam logic signed [OpW-1:0] OpMax = {1'b0, {(OpW-1){1'b1}}};
  localparam logic signed [OpW-1:0] OpMin = {1'b1, {(OpW-1){1'b0}}};
  localparam int unsigned PhaseItems = 300;
  localparam int unsigned HoldCycles = 200;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  in_item_t  in_item   = '0;
  logic      full;
  logic      empty;
  logic      pop       = 1'b0;
  out_item_t out_item;

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int items_sent     = 0;

  matmul_3xn_by_nx3_accumulate uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  mm3_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_item_i    (in_item),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop if the run hangs
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one item, idling first at random, and hold it until the block takes it
  task automatic push_item(input in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic push_fields(input logic [OpW-1:0] a0, input logic [OpW-1:0] a1,
                             input logic [OpW-1:0] a2, input logic [OpW-1:0] b0,
                             input logic [OpW-1:0] b1, input logic [OpW-1:0] b2,
                             input logic lst);
    in_item_t it;
    it.a_row0 = a0;
    it.a_row1 = a1;
    it.a_row2 = a2;
    it.b_col0 = b0;
    it.b_col1 = b1;
    it.b_col2 = b2;
    it.last   = lst;
    push_item(it);
  endtask

  // Operand mix: extremes, zero, small Q16.16 values and full-range noise
  function automatic logic [OpW-1:0] pick_operand();
    case ($urandom_range(9))
      0:       return OpMax;
      1:       return OpMin;
      2:       return '0;
      3, 4:    return OpW'($signed($urandom_range(2 << 16)) - $signed(1 << 16));
      default: return $urandom;
    endcase
  endfunction

  // One well-formed reduction of length n with random operands
  task automatic push_reduction(input int n);
    for (int k = 0; k < n; k++) begin
      push_fields(pick_operand(), pick_operand(), pick_operand(),
                  pick_operand(), pick_operand(), pick_operand(), k == n - 1);
    end
  endtask

  function automatic int pick_length();
    if ($urandom_range(9) == 0) return $urandom_range(40, 7);
    return $urandom_range(6, 1);
  endfunction

  // Drain results, stalling at random; hold off for a long stretch on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int phase_start;
    int guard;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero, extremes, mixed signs per lane
    push_fields('0, '0, '0, '0, '0, '0, 1'b1);
    push_fields(OpMax, OpMax, OpMax, OpMax, OpMax, OpMax, 1'b1);
    push_fields(OpMin, OpMin, OpMin, OpMin, OpMin, OpMin, 1'b1);
    push_fields(OpMin, OpMax, 32'sd1, OpMax, OpMin, -32'sd1, 1'b1);
    push_fields(32'h0001_0000, -32'sh0001_0000, 32'h0000_8000,
                32'h0002_0000, 32'h0000_0001, -32'sd1, 1'b1);
    // Positive saturation, then a negative product pulls the sums back off the limit
    repeat (3) push_fields(OpMin, OpMin, OpMin, OpMin, OpMin, OpMin, 1'b0);
    push_fields(OpMin, OpMin, OpMin, OpMax, OpMax, OpMax, 1'b1);
    // Negative saturation, then a positive product pulls the sums back up
    repeat (3) push_fields(OpMin, OpMin, OpMin, OpMax, OpMax, OpMax, 1'b0);
    push_fields(OpMin, OpMin, OpMin, OpMin, OpMin, OpMin, 1'b1);
    // Accumulate-only steps followed by a closing step
    push_fields(32'h0003_0000, 32'h0000_0002, -32'sh0004_0000,
                32'h0001_8000, -32'sd7, 32'h7FFF_0000, 1'b0);
    push_fields(32'h8000_0001, 32'h0000_0000, 32'h1234_5678,
                32'hFFFF_FFFF, 32'h7FFF_FFFE, 32'h0000_0001, 1'b0);
    push_fields(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000,
                32'h0000_FFFF, 32'h3333_3333, 32'hCCCC_CCCC, 1'b1);

    // Random reductions across the idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        push_reduction(pick_length());
      end
      // Back up the block: receiver holds off while short reductions keep coming
      if (phase == 0) begin
        hold_request = 1'b1;
        repeat (30) push_reduction(1);
      end
    end

    @(negedge clk_i);
    push <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Wait for every pending result, then a little longer for strays
    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
